>>> hdl/olt_pkg.sv
// Shared constants, codes and control types for the ordered list table.
`timescale 1ns / 1ps
package olt_pkg;

  // List geometry
  localparam int DEPTH = 16;
  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int ACT_W = 3;
  localparam int STS_W = 2;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ACT_W-1:0]        action_t;
  typedef logic [STS_W-1:0]        status_t;

  // Action codes
  localparam action_t ACT_APPEND  = 3'd0;
  localparam action_t ACT_DEL_VAL = 3'd1;
  localparam action_t ACT_DEL_POS = 3'd2;
  localparam action_t ACT_FIND    = 3'd3;
  localparam action_t ACT_READ    = 3'd4;
  localparam action_t ACT_DUMP    = 3'd5;

  // Result status codes
  localparam status_t STS_DONE = 2'd0;
  localparam status_t STS_MISS = 2'd1;
  localparam status_t STS_FULL = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic scan;
    logic exec;
    logic dump_next;
  } olt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic res_last;
  } olt_sts_t;

endpackage

>>> hdl/olt_req_if.sv
// Request channel: one action word with its operands.
`timescale 1ns / 1ps
interface olt_req_if;
  import olt_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  value_t  value;
  pos_t    position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink   (input valid, input action, input value, input position, output ready);
endinterface

>>> hdl/olt_rsp_if.sv
// Response channel: one result word per handshake.
`timescale 1ns / 1ps
interface olt_rsp_if;
  import olt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  pos_t    found_position;
  value_t  entry_value;
  cnt_t    entry_count;
  logic    last;

  modport source (output valid, output status, output found_position, output entry_value,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input status, input found_position, input entry_value,
                  input entry_count, input last, output ready);
endinterface

>>> hdl/olt_ctrl.sv
// Sequencing state machine for the ordered list table.
`timescale 1ns / 1ps
module olt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output olt_pkg::olt_cmd_t cmd,
  input  olt_pkg::olt_sts_t sts
);
  import olt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance through scan, execute, then hold the result until taken
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_OUT;
      ST_OUT:  if (out_ready && sts.res_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // Issue datapath commands
  always_comb begin
    cmd.load_in   = (state == ST_IDLE) && in_valid;
    cmd.scan      = (state == ST_SCAN);
    cmd.exec      = (state == ST_EXEC);
    cmd.dump_next = (state == ST_OUT) && out_ready && !sts.res_last;
  end

endmodule

>>> hdl/olt_dp.sv
// Entry table, match flags and result register for the ordered list table.
`timescale 1ns / 1ps
module olt_dp (
  input  logic              clk,
  input  logic              rst,
  input  olt_pkg::olt_cmd_t cmd,
  output olt_pkg::olt_sts_t sts,
  input  olt_pkg::action_t  in_action,
  input  olt_pkg::value_t   in_value,
  input  olt_pkg::pos_t     in_position,
  output olt_pkg::status_t  res_status,
  output olt_pkg::pos_t     res_position,
  output olt_pkg::value_t   res_value,
  output olt_pkg::cnt_t     res_count,
  output logic              res_last
);
  import olt_pkg::*;

  // Latched request
  action_t act_r;
  value_t  val_r;
  pos_t    pos_r;

  // List storage
  value_t           entries [DEPTH];
  cnt_t             count;
  logic [DEPTH-1:0] match_vec;
  pos_t             dump_idx;

  // Execute-step decisions
  status_t sts_next;
  pos_t    pos_next;
  value_t  val_next;
  cnt_t    cnt_next;
  logic    last_next;
  logic    app_en;
  logic    del_en;
  pos_t    del_idx;

  logic    hit;
  pos_t    first_idx;
  logic    pos_ok;
  pos_t    rd_idx;
  value_t  rd_data;
  pos_t    dump_pos_next;

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_action;
      val_r <= in_value;
      pos_r <= in_position;
    end
  end

  // Flag live entries equal to the request value
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_vec[i] <= (entries[i] == val_r) && (CNT_W'(i) < count);
      end
    end
  end

  // Pick the lowest flagged position
  always_comb begin
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) first_idx = POS_W'(i);
    end
  end
  assign hit = |match_vec;

  assign pos_ok  = ({1'b0, pos_r} < count);
  assign rd_idx  = (act_r == ACT_DUMP) ? dump_idx : pos_r;
  assign rd_data = entries[rd_idx];

  // Decide the action outcome
  always_comb begin
    sts_next  = STS_MISS;
    pos_next  = '0;
    val_next  = '0;
    cnt_next  = count;
    last_next = 1'b1;
    app_en    = 1'b0;
    del_en    = 1'b0;
    del_idx   = first_idx;
    unique case (act_r)
      ACT_APPEND: begin
        if (count < CNT_W'(DEPTH)) begin
          app_en   = 1'b1;
          sts_next = STS_DONE;
          pos_next = count[POS_W-1:0];
          val_next = val_r;
          cnt_next = count + CNT_W'(1);
        end else begin
          sts_next = STS_FULL;
        end
      end
      ACT_DEL_VAL: begin
        if (hit) begin
          del_en   = 1'b1;
          sts_next = STS_DONE;
          pos_next = first_idx;
          val_next = val_r;
          cnt_next = count - CNT_W'(1);
        end
      end
      ACT_DEL_POS: begin
        if (pos_ok) begin
          del_en   = 1'b1;
          del_idx  = pos_r;
          sts_next = STS_DONE;
          pos_next = pos_r;
          val_next = rd_data;
          cnt_next = count - CNT_W'(1);
        end
      end
      ACT_FIND: begin
        if (hit) begin
          sts_next = STS_DONE;
          pos_next = first_idx;
          val_next = val_r;
        end
      end
      ACT_READ: begin
        if (pos_ok) begin
          sts_next = STS_DONE;
          pos_next = pos_r;
          val_next = rd_data;
        end
      end
      ACT_DUMP: begin
        if (count != '0) begin
          sts_next  = STS_DONE;
          pos_next  = dump_idx;
          val_next  = rd_data;
          last_next = (count == CNT_W'(1));
        end
      end
      default: begin
        sts_next = STS_MISS;
      end
    endcase
  end

  // Append at the tail, or close the gap behind a deleted entry
  always_ff @(posedge clk) begin
    if (cmd.exec && app_en) begin
      entries[count[POS_W-1:0]] <= val_r;
    end else if (cmd.exec && del_en) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (POS_W'(i) >= del_idx) entries[i] <= entries[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= cnt_next;
    end
  end

  // Step the dump cursor
  assign dump_pos_next = dump_idx + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dump_idx <= '0;
    end else if (cmd.load_in) begin
      dump_idx <= '0;
    end else if (cmd.exec || cmd.dump_next) begin
      dump_idx <= dump_pos_next;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status   <= sts_next;
      res_position <= pos_next;
      res_value    <= val_next;
      res_count    <= cnt_next;
      res_last     <= last_next;
    end else if (cmd.dump_next) begin
      res_status   <= STS_DONE;
      res_position <= dump_idx;
      res_value    <= rd_data;
      res_count    <= count;
      res_last     <= ({1'b0, dump_idx} + CNT_W'(1) == count);
    end
  end

  assign sts.res_last = res_last;

endmodule

>>> hdl/ordered_list_table_unit.sv
// Top level of the ordered list table.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit values, packed from position 0.
// Each request word carries one action: append, delete by value, delete by
// position, find value, read position or dump. A request passes from
// acceptance to its result word through capture, compare of all live entries
// against the value, then execute and load the result register; the next
// request is taken in the cycle after the last result word is consumed. A dump
// gives one word per cycle while the sink is ready, count words in list
// order, with last set on the final one; an empty dump and every other
// action give a single word. Every word carries the entry count after the
// action.
module ordered_list_table_unit (
  input  logic       clk,
  input  logic       rst,
  olt_req_if.sink    req,
  olt_rsp_if.source  rsp
);
  import olt_pkg::*;

  olt_cmd_t cmd;
  olt_sts_t sts;

  olt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  olt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (req.action),
    .in_value     (req.value),
    .in_position  (req.position),
    .res_status   (rsp.status),
    .res_position (rsp.found_position),
    .res_value    (rsp.entry_value),
    .res_count    (rsp.entry_count),
    .res_last     (rsp.last)
  );

endmodule

>>> dv/tb.sv
// Testbench for the ordered list table: queued request driver, checking response monitor.
`timescale 1ns / 1ps
module tb;
  import olt_pkg::*;

  // Action codes the block does not define; both must give a miss
  localparam action_t ACT_SPARE_LO = 3'd6;
  localparam action_t ACT_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT = 600000;
  localparam int CALM_TAIL   = 40;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT     = 120;

  typedef struct {
    action_t action;
    value_t  value;
    pos_t    position;
    bit      drain;
  } list_req_t;

  typedef struct {
    status_t status;
    pos_t    position;
    value_t  value;
    cnt_t    count;
    logic    last;
  } list_word_t;

  logic clk;
  logic rst;

  olt_req_if req_ch ();
  olt_rsp_if rsp_ch ();

  ordered_list_table_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_req_t  req_backlog[$];
  list_word_t due_words[$];

  // Shadow copy of the list
  value_t shadow_vals[DEPTH];
  int     shadow_len;

  int err_cnt;
  int cycle_cnt;
  int sent_cnt;
  int total_reqs;
  int words_seen;
  int gap_left;
  int stall_left;
  int hold_left;
  bit held_once;
  logic ready_next;
  list_req_t  next_req;
  list_word_t exp_word;
  value_t     val_pool[8];

  // No idling once the backlog runs low
  function automatic bit calm();
    return (req_backlog.size() < CALM_TAIL);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Queue the expected words of one accepted request and update the shadow list
  task automatic predict_words(input action_t act, input value_t val, input pos_t pos);
    int idx;
    value_t taken;
    idx = -1;
    taken = '0;
    case (act)
      ACT_APPEND: begin
        if (shadow_len >= DEPTH) begin
          due_words.push_back('{STS_FULL, '0, '0, cnt_t'(shadow_len), 1'b1});
        end else begin
          shadow_vals[shadow_len] = val;
          shadow_len++;
          due_words.push_back('{STS_DONE, pos_t'(shadow_len - 1), val,
                                cnt_t'(shadow_len), 1'b1});
        end
      end
      ACT_DEL_VAL, ACT_FIND: begin
        for (int i = shadow_len - 1; i >= 0; i--) begin
          if (shadow_vals[i] == val) idx = i;
        end
        if (idx < 0) begin
          due_words.push_back('{STS_MISS, '0, '0, cnt_t'(shadow_len), 1'b1});
        end else begin
          if (act == ACT_DEL_VAL) begin
            for (int i = idx; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i + 1];
            shadow_len--;
          end
          due_words.push_back('{STS_DONE, pos_t'(idx), val, cnt_t'(shadow_len), 1'b1});
        end
      end
      ACT_DEL_POS, ACT_READ: begin
        if (int'(pos) >= shadow_len) begin
          due_words.push_back('{STS_MISS, '0, '0, cnt_t'(shadow_len), 1'b1});
        end else begin
          taken = shadow_vals[pos];
          if (act == ACT_DEL_POS) begin
            for (int i = pos; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i + 1];
            shadow_len--;
          end
          due_words.push_back('{STS_DONE, pos, taken, cnt_t'(shadow_len), 1'b1});
        end
      end
      ACT_DUMP: begin
        if (shadow_len == 0) begin
          due_words.push_back('{STS_MISS, '0, '0, '0, 1'b1});
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            due_words.push_back('{STS_DONE, pos_t'(i), shadow_vals[i], cnt_t'(shadow_len),
                                  logic'(i == shadow_len - 1)});
          end
        end
      end
      default: begin
        due_words.push_back('{STS_MISS, '0, '0, cnt_t'(shadow_len), 1'b1});
      end
    endcase
  endtask

  task automatic add_req(input action_t act, input value_t val, input pos_t pos,
                         input bit drain = 1'b0);
    req_backlog.push_back('{act, val, pos, drain});
  endtask

  task automatic flag_field(input string field, input longint expv, input longint actv);
    $error("%s mismatch: expected %0d, got %0d", field, expv, actv);
    err_cnt++;
  endtask

  // Build the random part: alternating grow and shrink phases over a small value pool
  task automatic fill_random();
    int pick;
    action_t act;
    value_t val;
    for (int ph = 0; ph < 14; ph++) begin
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(0, 3))
          0: val_pool[k] = $urandom;
          1: val_pool[k] = $urandom_range(0, 15);
          2: val_pool[k] = -$signed($urandom_range(1, 15));
          default: val_pool[k] = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        endcase
      end
      for (int n = 0; n < 30; n++) begin
        pick = $urandom_range(0, 99);
        if (ph % 2 == 0) begin
          if (pick < 50)      act = ACT_APPEND;
          else if (pick < 65) act = ACT_FIND;
          else if (pick < 75) act = ACT_READ;
          else if (pick < 82) act = ACT_DEL_VAL;
          else if (pick < 89) act = ACT_DEL_POS;
          else if (pick < 97) act = ACT_DUMP;
          else                act = (pick == 97) ? ACT_SPARE_LO : ACT_SPARE_HI;
        end else begin
          if (pick < 15)      act = ACT_APPEND;
          else if (pick < 45) act = ACT_DEL_VAL;
          else if (pick < 70) act = ACT_DEL_POS;
          else if (pick < 80) act = ACT_FIND;
          else if (pick < 89) act = ACT_READ;
          else if (pick < 97) act = ACT_DUMP;
          else                act = (pick == 97) ? ACT_SPARE_LO : ACT_SPARE_HI;
        end
        val = ($urandom_range(0, 4) != 0) ? val_pool[$urandom_range(0, 7)] : value_t'($urandom);
        add_req(act, val, pos_t'($urandom_range(0, DEPTH - 1)), (ph == 7 && n == 0));
      end
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_APPEND;
    req_ch.value = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;
    err_cnt = 0;
    shadow_len = 0;
    for (int i = 0; i < DEPTH; i++) shadow_vals[i] = '0;

    // Empty list: dump, read, find and the spare codes all miss
    add_req(ACT_DUMP, '0, '0);
    add_req(ACT_READ, '0, '0);
    add_req(ACT_FIND, 32'sd5, '0);
    add_req(ACT_SPARE_LO, '0, '0);
    add_req(ACT_SPARE_HI, 32'sh7fffffff, 4'hf);
    // Fill to capacity with extremes and duplicates
    add_req(ACT_APPEND, 32'sh80000000, 4'hf);
    add_req(ACT_APPEND, 32'sh7fffffff, '0);
    add_req(ACT_APPEND, 32'sd0, '0);
    add_req(ACT_APPEND, -32'sd1, '0);
    add_req(ACT_APPEND, 32'sd1, '0);
    add_req(ACT_APPEND, 32'sh55555555, '0);
    add_req(ACT_APPEND, 32'shaaaaaaaa, '0);
    add_req(ACT_APPEND, 32'sd7, '0);
    add_req(ACT_APPEND, 32'sd7, '0);
    add_req(ACT_APPEND, 32'sh12345678, '0);
    add_req(ACT_APPEND, -32'sd100, '0);
    add_req(ACT_APPEND, 32'sd100, '0);
    add_req(ACT_APPEND, 32'sh0f0f0f0f, '0);
    add_req(ACT_APPEND, 32'shf0f0f0f0, '0);
    add_req(ACT_APPEND, 32'sd7, '0);
    add_req(ACT_APPEND, 32'sd42, '0);
    // Full list, full dump, a delete by value that closes a gap, then a delete past the tail and a find
    add_req(ACT_APPEND, 32'sd99, '0);
    add_req(ACT_DUMP, '0, '0, 1'b1);
    add_req(ACT_DEL_VAL, 32'sd7, '0);
    add_req(ACT_DEL_POS, '0, 4'hf);
    add_req(ACT_FIND, 32'sd7, '0);
    fill_random();
    total_reqs = req_backlog.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be accepted and every word to come back
    while (sent_cnt < total_reqs) @(posedge clk);
    while (due_words.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
      sent_cnt = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_words(req_ch.action, req_ch.value, req_ch.position);
        sent_cnt++;
        if (!calm() && ((sent_cnt / 48) % 4 != 3) && ($urandom_range(0, 3) == 0))
          gap_left = $urandom_range(1, 12);
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered word
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (req_backlog.size() > 0 && !(req_backlog[0].drain && due_words.size() > 0)) begin
        next_req = req_backlog.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= next_req.action;
        req_ch.value <= next_req.value;
        req_ch.position <= next_req.position;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response monitor and sink stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      held_once = 1'b0;
      words_seen = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        words_seen++;
        if (due_words.size() == 0) begin
          $error("result word with nothing expected: status %0d position %0d",
                 rsp_ch.status, rsp_ch.found_position);
          err_cnt++;
        end else begin
          exp_word = due_words.pop_front();
          if (rsp_ch.status !== exp_word.status)
            flag_field("status", exp_word.status, rsp_ch.status);
          if (rsp_ch.found_position !== exp_word.position)
            flag_field("found_position", exp_word.position, rsp_ch.found_position);
          if (rsp_ch.entry_value !== exp_word.value)
            flag_field("entry_value", exp_word.value, rsp_ch.entry_value);
          if (rsp_ch.entry_count !== exp_word.count)
            flag_field("entry_count", exp_word.count, rsp_ch.entry_count);
          if (rsp_ch.last !== exp_word.last)
            flag_field("last", exp_word.last, rsp_ch.last);
        end
        if (words_seen == HOLD_AT && !held_once) begin
          held_once = 1'b1;
          hold_left = LONG_HOLD;
        end
      end
      // Drop ready for the long hold-off or a short burst, else accept
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!calm() && ((words_seen / 64) % 4 != 2) && ($urandom_range(0, 4) == 0)) begin
        stall_left = $urandom_range(0, 11);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      rsp_ch.ready <= ready_next;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule
